[design/gsc_pkg.sv]
// Shared types and constants for the Gray sequence checker.
package gsc_pkg;

  // Code word and width register sizes
  localparam int CODE_W  = 10;
  localparam int WIDTH_W = 4;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd4;

  // Visited-map entries hold a sequence tag; zero never matches a live tag
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = 8'd0;

  // Register map
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_WIDTH_BITS = 1'b0;

  typedef logic [CODE_W-1:0] code_t;

  // True when a and b differ in exactly one bit
  function automatic logic one_bit_apart(input code_t a, input code_t b);
    code_t x;
    x = a ^ b;
    return (x != '0) && ((x & (x - code_t'(1))) == '0);
  endfunction

endpackage

[design/gsc_map_ram.sv]
// Visited map: simple dual-port RAM, one write and one registered read port.
module gsc_map_ram #(
  parameter int AW = 10,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  // Read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/gsc_apb_regs.sv]
// APB configuration register: code width.
module gsc_apb_regs
  import gsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  output logic [WIDTH_W-1:0] width_bits
);

  logic [WIDTH_W-1:0] width_bits_r;
  logic               wr_en;

  // Word index is paddr[2]; byte offset bits are ignored
  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_WIDTH_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_bits_r <= WIDTH_RESET;
    end else if (wr_en) begin
      width_bits_r <= pwdata[WIDTH_W-1:0];
    end
  end

  // Read back; unmapped word reads zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WIDTH_BITS) begin
      prdata = CFG_DW'(width_bits_r);
    end
  end

  assign pready     = 1'b1;
  assign width_bits = width_bits_r;

endmodule

[design/gsc_seq_check.sv]
// Checker pipeline: map lookup, per-word checks, sequence state and verdict.
module gsc_seq_check
  import gsc_pkg::*;
#(
  parameter int MAX_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WIDTH_W-1:0] width_bits,
  input  logic               in_valid,
  output logic               in_ready,
  input  code_t              in_code,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_seq_valid,
  output logic               ram_we,
  output logic [MAX_BITS-1:0] ram_waddr,
  output logic [EPOCH_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [MAX_BITS-1:0] ram_raddr,
  input  logic [EPOCH_W-1:0] ram_rdata
);

  localparam int MAP_AW = MAX_BITS;
  localparam int CNT_W  = MAX_BITS + 1;

  // Stage 1 item and lookup side info
  logic                s1_valid_r;
  code_t               s1_code_r;
  logic                s1_last_r;
  logic [MAP_AW-1:0]   s1_idx_r;
  logic                fwd_hit_r;

  // Sequence state
  code_t               first_r;
  code_t               prev_r;
  logic [CNT_W-1:0]    count_r;
  logic                fault_r;
  logic [EPOCH_W-1:0]  epoch_r;

  // Clearing pass
  logic                clr_r;
  logic [MAP_AW-1:0]   clr_addr_r;

  // Result register
  logic                out_valid_r;
  logic                out_ok_r;

  logic                s1_fire;
  logic                wrap_now;
  logic                accept;
  logic [MAP_AW-1:0]   in_idx;
  logic                width_ok;
  logic                range_bad;
  logic                seen;
  logic                step_bad;
  logic                fault_nxt;
  logic [CNT_W-1:0]    count_nxt;
  code_t               first_nxt;
  logic                ok_nxt;

  assign in_idx   = MAP_AW'(in_code);
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign wrap_now = s1_valid_r && s1_last_r && (epoch_r == EPOCH_LAST);
  assign in_ready = !clr_r && (!s1_valid_r || s1_fire) && !wrap_now;
  assign accept   = in_valid && in_ready;

  // Map read on accept; data arrives with the item in stage 1
  assign ram_re    = accept;
  assign ram_raddr = in_idx;

  // Map write: sweep during clearing, else mark the word of this sequence
  always_comb begin
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = EPOCH_CLEAR;
    end else begin
      ram_we    = s1_fire;
      ram_waddr = s1_idx_r;
      ram_wdata = epoch_r;
    end
  end

  // Per-word checks
  assign width_ok  = (width_bits != '0) && (32'(width_bits) <= MAX_BITS);
  assign range_bad = (s1_code_r >> width_bits) != '0;
  assign seen      = fwd_hit_r || (ram_rdata == epoch_r);
  assign step_bad  = (count_r != '0) && !one_bit_apart(s1_code_r, prev_r);
  assign fault_nxt = fault_r || !width_ok || range_bad || seen || step_bad;
  assign count_nxt = (count_r == '1) ? count_r : count_r + CNT_W'(1);
  assign first_nxt = (count_r == '0) ? s1_code_r : first_r;

  // Verdict at the last word
  assign ok_nxt = !fault_nxt && width_ok && one_bit_apart(s1_code_r, first_nxt)
                  && (count_nxt == (CNT_W'(1) << width_bits));

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code_r <= in_code;
      s1_last_r <= in_last;
      s1_idx_r  <= in_idx;
      // Word leaving stage 1 now writes after this read: forward it
      fwd_hit_r <= s1_fire && !s1_last_r && (s1_idx_r == in_idx);
    end
  end

  // Sequence state, tag and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r    <= '0;
      prev_r     <= '0;
      count_r    <= '0;
      fault_r    <= 1'b0;
      epoch_r    <= EPOCH_FIRST;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + MAP_AW'(1);
        if (clr_addr_r == '1) begin
          clr_r <= 1'b0;
        end
      end
      if (s1_fire) begin
        if (s1_last_r) begin
          first_r <= '0;
          prev_r  <= '0;
          count_r <= '0;
          fault_r <= 1'b0;
          if (epoch_r == EPOCH_LAST) begin
            epoch_r    <= EPOCH_FIRST;
            clr_r      <= 1'b1;
            clr_addr_r <= '0;
          end else begin
            epoch_r <= epoch_r + EPOCH_W'(1);
          end
        end else begin
          first_r <= first_nxt;
          prev_r  <= s1_code_r;
          count_r <= count_nxt;
          fault_r <= fault_nxt;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_ok_r <= ok_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_seq_valid = out_ok_r;

endmodule

[design/gray_sequence_checker.sv]
// Gray sequence checker: accepts one code word per cycle while in_ready is
// high and, on the word marked last, reports whether the sequence was a
// complete cyclic Gray sequence of the configured width. Each word passes a
// lookup in the visited map (a one-write, one-read RAM of 2^MAX_BITS tag
// entries) and then a check stage before the verdict; a word that repeats the
// one just before it is forwarded, so the map never holds up the stream. The
// map is not swept between sequences: each sequence has its own tag. After
// reset, and after every 255th sequence, a clearing pass over all 2^MAX_BITS
// entries runs while in_ready is low; the register port stays usable. A pending
// verdict stalls input only when a second last word arrives before it is taken.
module gray_sequence_checker
  import gsc_pkg::*;
#(
  parameter int MAX_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  // Input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic              in_last_word,
  // Results
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_sequence_valid,
  output logic              out_result_last
);

  logic [WIDTH_W-1:0]  width_bits;
  logic                ram_we;
  logic [MAX_BITS-1:0] ram_waddr;
  logic [EPOCH_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [MAX_BITS-1:0] ram_raddr;
  logic [EPOCH_W-1:0]  ram_rdata;

  gsc_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .width_bits (width_bits)
  );

  gsc_seq_check #(
    .MAX_BITS (MAX_BITS)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .width_bits    (width_bits),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code       (in_code_value),
    .in_last       (in_last_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_seq_valid (out_sequence_valid),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  gsc_map_ram #(
    .AW (MAX_BITS),
    .DW (EPOCH_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Every result closes a sequence
  assign out_result_last = 1'b1;

endmodule

[test/tb.sv]
// Testbench for the Gray sequence checker: random streamed sequences scored against a predictor.
`timescale 1ns / 1ps

module tb
  import gsc_pkg::*;
;

  localparam int MAP_BITS = 10;
  localparam int RANDOM_ITEMS = 1550;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [10:0] COUNT_SAT = '1;

  typedef struct packed {
    code_t code;
    logic  last;
  } word_item_t;

  // Ways a generated Gray sequence gets damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_SWAP,
    FLAW_REPEAT,
    FLAW_DROP,
    FLAW_EXTRA,
    FLAW_RANGE,
    FLAW_FLIP,
    FLAW_EARLY
  } seq_flaw_t;

  // Receiver behavior for a stretch of cycles
  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_HOLD
  } drain_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CODE_W-1:0] in_code_value = '0;
  logic              in_last_word = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_sequence_valid;
  logic              out_result_last;

  gray_sequence_checker #(
    .MAX_BITS(MAP_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_code_value(in_code_value),
    .in_last_word(in_last_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sequence_valid(out_sequence_valid),
    .out_result_last(out_result_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectations
  word_item_t pending_q[$];
  logic       verdict_q[$];
  int         mismatches = 0;
  int         words_queued = 0;
  int         cycle_count = 0;
  int         gen_width = int'(WIDTH_RESET);

  // Predictor state, mirrors the block after reset
  logic [WIDTH_W-1:0]     width_now = WIDTH_RESET;
  logic [(1<<MAP_BITS)-1:0] seen_map = '0;
  code_t                  head_word = '0;
  code_t                  prior_word = '0;
  logic [10:0]            word_total = '0;
  logic                   seq_fault = 1'b0;

  // Score one accepted word; a last word yields the sequence verdict
  task automatic score_word(input code_t code, input logic last);
    logic  width_ok;
    logic  ok;
    code_t mask;
    width_ok = (width_now >= 1) && (width_now <= MAP_BITS);
    mask = width_ok ? code_t'((1 << width_now) - 1) : '0;
    if (!width_ok || (code & ~mask) != '0) seq_fault = 1'b1;
    if (seen_map[code]) seq_fault = 1'b1;
    seen_map[code] = 1'b1;
    if (word_total == '0) head_word = code;
    else if ($countones(code ^ prior_word) != 1) seq_fault = 1'b1;
    prior_word = code;
    if (word_total != COUNT_SAT) word_total = word_total + 1'b1;
    if (last) begin
      ok = !seq_fault && width_ok && ($countones(code ^ head_word) == 1);
      if (width_ok && int'(word_total) != (1 << width_now)) ok = 1'b0;
      verdict_q.push_back(ok);
      seen_map = '0;
      head_word = '0;
      prior_word = '0;
      word_total = '0;
      seq_fault = 1'b0;
    end
  endtask

  // Monitor: results checked before the new word is scored
  logic in_taken = 1'b0;

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) width_now = pwdata[WIDTH_W-1:0];
      if (psel && penable && !pwrite && pready && prdata[WIDTH_W-1:0] != width_now) begin
        $display("%0t: width readback expected %0d got %0d", $time, width_now,
                 prdata[WIDTH_W-1:0]);
        mismatches++;
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict expected none got %0d", $time, out_sequence_valid);
          mismatches++;
        end else begin
          logic want;
          want = verdict_q.pop_front();
          if (out_sequence_valid !== want) begin
            $display("%0t: sequence_valid expected %0d got %0d", $time, want,
                     out_sequence_valid);
            mismatches++;
          end
          if (out_result_last !== 1'b1) begin
            $display("%0t: result_last expected 1 got %0d", $time, out_result_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) score_word(in_code_value, in_last_word);
    end
  end

  // Driver: bursts of words with random gaps between them
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left != 0 || pending_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        word_item_t item;
        item = pending_q.pop_front();
        in_valid <= 1'b1;
        in_code_value <= item.code;
        in_last_word <= item.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern picked at random, switched after each random-length run
  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_run = 0;

  always @(negedge clk) begin
    if (drain_run == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(DRAIN_FREE, DRAIN_HOLD));
      drain_run <= $urandom_range(8, 60);
    end else begin
      drain_run <= drain_run - 1;
    end
    case (drain_mode)
      DRAIN_FREE: begin
        out_ready <= 1'b1;
      end
      DRAIN_COIN: begin
        out_ready <= ($urandom_range(0, 1) != 0);
      end
      DRAIN_SPARSE: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= 1'b0;
      end
    endcase
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_word(input code_t code, input logic last);
    word_item_t item;
    item.code = code;
    item.last = last;
    pending_q.push_back(item);
    words_queued++;
  endtask

  // Wait until every queued word is taken and every verdict is in
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write then readback, only once the block is idle
  task automatic write_width(input logic [WIDTH_W-1:0] w);
    logic [CFG_DW-WIDTH_W-1:0] upper;
    upper = '0;
    if ($urandom_range(0, 1) != 0) upper = (CFG_DW-WIDTH_W)'($urandom);
    wait_idle();
    gen_width = int'(w);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(REG_WIDTH_BITS) << 2;
    pwdata <= {upper, w};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Cyclic Gray sequence of width w: rotated, possibly reversed, XOR-shifted, then flawed
  task automatic queue_sequence(input int w, input seq_flaw_t flaw);
    code_t words[$];
    code_t mask;
    int    n, start, shift_mask, k, a, b, i;
    logic  rev;
    n = 1 << w;
    mask = code_t'(n - 1);
    start = $urandom_range(0, n - 1);
    shift_mask = $urandom_range(0, n - 1);
    rev = ($urandom_range(0, 1) != 0);
    for (i = 0; i < n; i++) begin
      k = rev ? ((start + n - i) & (n - 1)) : ((start + i) & (n - 1));
      words.push_back(code_t'((k ^ (k >> 1)) ^ shift_mask));
    end
    a = $urandom_range(0, n - 1);
    b = (a + $urandom_range(1, n - 1)) % n;
    case (flaw)
      FLAW_SWAP: begin
        words[a] = words[a] ^ words[b];
        words[b] = words[a] ^ words[b];
        words[a] = words[a] ^ words[b];
      end
      FLAW_REPEAT: begin
        words[b] = words[a];
      end
      FLAW_DROP: begin
        words.delete(a);
      end
      FLAW_EXTRA: begin
        words.push_back(code_t'($urandom) & mask);
      end
      FLAW_RANGE: begin
        if (w < CODE_W) words[a] = words[a] | (code_t'(1) << $urandom_range(w, CODE_W - 1));
        else words[a] = words[a] ^ code_t'(1);
      end
      FLAW_FLIP: begin
        words[a] = words[a] ^ (code_t'(1) << $urandom_range(0, w - 1));
      end
      FLAW_EARLY: begin
        k = $urandom_range(1, n - 1);
        while (words.size() > k) void'(words.pop_back());
      end
      default: begin
      end
    endcase
    for (i = 0; i < words.size(); i++) push_word(words[i], i == words.size() - 1);
  endtask

  // Loose words, in and out of range, ending on a last mark
  task automatic queue_noise();
    int    count, i;
    code_t code;
    count = $urandom_range(1, 10);
    for (i = 0; i < count; i++) begin
      code = code_t'($urandom);
      if ($urandom_range(0, 1) && gen_width >= 1 && gen_width <= CODE_W)
        code = code & code_t'((1 << gen_width) - 1);
      push_word(code, (i == count - 1) || ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    int        random_start, phase_seqs, r, w, s;
    seq_flaw_t flaw;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset width: in-range word then all-ones word out of range
    push_word(code_t'(0), 1'b0);
    push_word(code_t'(1023), 1'b1);

    // Width one: both directions, a lone word and a repeated word
    write_width(WIDTH_W'(1));
    push_word(code_t'(0), 1'b0);
    push_word(code_t'(1), 1'b1);
    push_word(code_t'(1), 1'b0);
    push_word(code_t'(0), 1'b1);
    push_word(code_t'(0), 1'b1);
    push_word(code_t'(1), 1'b0);
    push_word(code_t'(1), 1'b1);

    // Width zero and width above the map size are always rejected
    write_width(WIDTH_W'(0));
    push_word(code_t'(0), 1'b0);
    push_word(code_t'(1), 1'b1);
    write_width(WIDTH_W'(15));
    push_word(code_t'(512), 1'b0);
    push_word(code_t'(513), 1'b1);

    // Width raised mid-sequence: first half checked at 2 bits, length at 3
    write_width(WIDTH_W'(2));
    push_word(code_t'(0), 1'b0);
    push_word(code_t'(1), 1'b0);
    push_word(code_t'(3), 1'b0);
    push_word(code_t'(2), 1'b0);
    write_width(WIDTH_W'(3));
    push_word(code_t'(6), 1'b0);
    push_word(code_t'(7), 1'b0);
    push_word(code_t'(5), 1'b0);
    push_word(code_t'(4), 1'b1);

    // One full sweep at the widest setting
    random_start = words_queued;
    write_width(WIDTH_W'(MAP_BITS));
    queue_sequence(MAP_BITS, FLAW_NONE);

    // Random phases, mostly small widths
    while (words_queued - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) w = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(MAP_BITS + 1, 15);
      else if (r < 75) w = $urandom_range(1, 4);
      else if (r < 95) w = $urandom_range(5, 6);
      else w = $urandom_range(7, 8);
      write_width(WIDTH_W'(w));
      phase_seqs = $urandom_range(2, 8);
      for (s = 0; s < phase_seqs; s++) begin
        r = $urandom_range(0, 9);
        if (r == 9) begin
          queue_noise();
        end else begin
          flaw = (r < 7) ? FLAW_NONE : seq_flaw_t'($urandom_range(FLAW_SWAP, FLAW_EARLY));
          queue_sequence((w >= 1 && w <= MAP_BITS) ? w : $urandom_range(1, 3), flaw);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/gsc_pkg.sv
design/gsc_map_ram.sv
design/gsc_apb_regs.sv
design/gsc_seq_check.sv
design/gray_sequence_checker.sv
test/tb.sv
